### rtl/cvd_pkg.sv
// ----------------------------------------------------------------------------
// cvd_pkg: shared types and constants for the canonical varint decoder
// Holds the status codes, the result beat structure and the group constants.
// ----------------------------------------------------------------------------
package cvd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned GroupW   = 7;
  localparam int unsigned ShiftW   = 7;
  localparam int unsigned StatusW  = 3;

  // group position at which only a single bit of payload still fits
  localparam logic [ShiftW-1:0] TopShift  = 7'd63;
  // group-position bound at or past which a group is an eleventh group
  localparam logic [ShiftW-1:0] OverShift = 7'd64;
  localparam logic [ShiftW-1:0] ShiftStep = 7'd7;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NONCANON  = 3'd4
  } status_t;

  // one decoded beat leaving the decode step
  typedef struct packed {
    logic              vld;
    logic [ValueW-1:0] value;
    status_t           status;
  } res_t;

endpackage

### rtl/cvd_in_stage.sv
// ----------------------------------------------------------------------------
// cvd_in_stage: input register
// Captures one byte beat per cycle and holds it while the decode step waits.
// ----------------------------------------------------------------------------
module cvd_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [cvd_pkg::ByteW-1:0] in_data_byte,
  input  logic                      in_last_in_buffer,
  input  logic                      take,
  output logic                      vld,
  output logic [cvd_pkg::ByteW-1:0] data_byte,
  output logic                      last
);
  import cvd_pkg::*;

  logic             vld_r,  vld_nxt;
  logic [ByteW-1:0] byte_r;
  logic             last_r;
  logic             load;

  // the register frees up in the same cycle that the step consumes it
  assign load     = !vld_r || take;
  assign in_stall = !load;
  assign vld_nxt  = load ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      byte_r <= in_data_byte;
      last_r <= in_last_in_buffer;
    end
  end

  assign vld       = vld_r;
  assign data_byte = byte_r;
  assign last      = last_r;

endmodule

### rtl/cvd_step.sv
// ----------------------------------------------------------------------------
// cvd_step: varint decode step
// Folds one byte into the partial value and raises a result beat on a
// completed varint or on the first error of a buffer.
// ----------------------------------------------------------------------------
module cvd_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [cvd_pkg::ByteW-1:0] data_byte,
  input  logic                      last,
  output cvd_pkg::res_t             res
);
  import cvd_pkg::*;

  logic [ValueW-1:0]  partial_r, partial_nxt;
  logic [ShiftW-1:0]  shift_r,   shift_nxt;
  status_t            latch_r,   latch_nxt;

  logic [GroupW-1:0]  chunk;
  logic [ValueW-1:0]  merged;

  assign chunk  = data_byte[GroupW-1:0];
  assign merged = partial_r | (ValueW'(chunk) << shift_r[5:0]);

  always_comb begin
    status_t fail;
    fail        = ST_OK;
    partial_nxt = partial_r;
    shift_nxt   = shift_r;
    latch_nxt   = latch_r;
    res.vld     = 1'b0;
    res.value   = '0;
    res.status  = ST_OK;

    if (latch_r == ST_OK) begin
      if (shift_r >= OverShift) begin
        fail = ST_MALFORMED;
      end else if (shift_r == TopShift && chunk > GroupW'(1)) begin
        fail = ST_RANGE;
      end else if (!data_byte[ByteW-1]) begin
        if (data_byte == '0 && shift_r != '0) begin
          fail = ST_NONCANON;
        end else begin
          res.vld     = 1'b1;
          res.value   = merged;
          partial_nxt = '0;
          shift_nxt   = '0;
        end
      end else begin
        partial_nxt = merged;
        shift_nxt   = shift_r + ShiftStep;
        if (last) begin
          fail = ST_TRUNC;
        end
      end

      if (fail != ST_OK) begin
        latch_nxt   = fail;
        partial_nxt = '0;
        shift_nxt   = '0;
        res.vld     = 1'b1;
        res.value   = '0;
        res.status  = fail;
      end
    end

    // buffer boundary: drop everything gathered so far
    if (last) begin
      partial_nxt = '0;
      shift_nxt   = '0;
      latch_nxt   = ST_OK;
    end

    if (!go) begin
      res.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      shift_r   <= '0;
      latch_r   <= ST_OK;
    end else if (go) begin
      partial_r <= partial_nxt;
      shift_r   <= shift_nxt;
      latch_r   <= latch_nxt;
    end
  end

endmodule

### rtl/cvd_out_stage.sv
// ----------------------------------------------------------------------------
// cvd_out_stage: result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module cvd_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cvd_pkg::res_t              res,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cvd_pkg::ValueW-1:0] out_decoded_value,
  output logic [cvd_pkg::StatusW-1:0] out_result_status
);
  import cvd_pkg::*;

  logic              vld_r, vld_nxt;
  logic [ValueW-1:0] value_r;
  status_t           status_r;

  assign free    = !vld_r || !out_stall;
  assign vld_nxt = res.vld ? 1'b1 : (free ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      value_r  <= res.value;
      status_r <= res.status;
    end
  end

  assign out_valid         = vld_r;
  assign out_decoded_value = value_r;
  assign out_result_status = StatusW'(status_r);

endmodule

### rtl/canonical_varint_decoder.sv
// ----------------------------------------------------------------------------
// canonical_varint_decoder: canonical unsigned LEB128 stream decoder
// Decodes back-to-back 64-bit base-128 varints from a byte stream, one
// byte beat per cycle while not stalled, and reports completed values and
// the first error of each buffer.
//
// Usage:
//   Input channel (in_): one byte per beat plus a flag on the buffer's last
//   byte. Output channel (out_): decoded value and status; the value reads
//   zero on any error status. A beat gives zero or one result.
//   Path: an accepted byte sits in the input register, passes the
//   combinational decode step and lands in the result register, from
//   which the receiver takes its result.
//   Throughput: one byte per cycle while not stalled; the decode step is a
//   64-bit shift-and-OR plus a few small compares between the two registers.
//   Reset: rst_n (synchronous) empties both registers and clears the
//   partial value, group position and error latch.
//   Stall: while out_stall holds a result, the decode step waits; the input
//   register still holds one more byte, after which in_stall rises.
// ----------------------------------------------------------------------------
module canonical_varint_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cvd_pkg::ByteW-1:0]   in_data_byte,
  input  logic                        in_last_in_buffer,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cvd_pkg::ValueW-1:0]  out_decoded_value,
  output logic [cvd_pkg::StatusW-1:0] out_result_status
);
  import cvd_pkg::*;

  logic             st_vld;
  logic [ByteW-1:0] st_byte;
  logic             st_last;
  logic             out_free;
  logic             step_go;
  res_t             step_res;

  // advance a held byte whenever the result register can take a beat
  assign step_go = st_vld && out_free;

  cvd_in_stage u_in (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_in_buffer (in_last_in_buffer),
    .take              (step_go),
    .vld               (st_vld),
    .data_byte         (st_byte),
    .last              (st_last)
  );

  cvd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (step_go),
    .data_byte (st_byte),
    .last      (st_last),
    .res       (step_res)
  );

  cvd_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res               (step_res),
    .free              (out_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_decoded_value (out_decoded_value),
    .out_result_status (out_result_status)
  );

endmodule
